### src/dwev_pkg.sv
package dwev_pkg;

    // Width of the value field on the result channel.
    localparam int unsigned DATA_W = 64;

    // Default width of the kept part of a decoded value.
    localparam int unsigned VALUE_W_DEFAULT = 64;

    // Width of the saturating byte counter.
    localparam int unsigned COUNT_W = 4;

    // Largest byte count that is still reported exactly.
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(15);

    // Last LEB128 byte index whose payload bits still start below DATA_W.
    localparam logic [COUNT_W-1:0] LEB_LAST_IDX = COUNT_W'((DATA_W - 1) / 7);

    // Encoding modes as carried on the input channel.
    typedef enum logic [2:0] {
        MODE_ULEB = 3'd0,
        MODE_U16  = 3'd1,
        MODE_U32  = 3'd2,
        MODE_U64  = 3'd3,
        MODE_SLEB = 3'd4,
        MODE_S16  = 3'd5,
        MODE_S32  = 3'd6,
        MODE_S64  = 3'd7
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] mode;
    } t_in_beat;

    typedef struct packed {
        logic [DATA_W-1:0]  decoded_value;
        logic [COUNT_W-1:0] byte_count;
        logic               overflow;
    } t_out_beat;

    // Per-value decoding state, apart from the accumulator itself.
    typedef struct packed {
        logic               in_value;
        t_mode              mode;
        logic [COUNT_W-1:0] bytes_seen;
        logic               dropped;
    } t_ctl;

endpackage

### src/dwev_step.sv
module dwev_step
    import dwev_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_W_DEFAULT
) (
    input  t_in_beat               i_beat,
    input  t_ctl                   i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_acc,
    output t_ctl                   o_ctl,
    output logic [VALUE_WIDTH-1:0] o_acc,
    output logic                   o_done,
    output t_out_beat              o_result
);

    // Number of LEB128 bytes that reach into VALUE_WIDTH; any byte beyond drops bits.
    localparam logic [COUNT_W-1:0] LEB_MAX_BYTES = COUNT_W'((VALUE_WIDTH + 6) / 7);

    t_ctl                   cur;
    logic [VALUE_WIDTH-1:0] cur_acc;
    logic [VALUE_WIDTH-1:0] acc;
    logic [COUNT_W-1:0]     count;
    logic [6:0]             bit_pos;
    logic [6:0]             sext_pos;
    logic [5:0]             byte_shift;
    logic [3:0]             nbytes;
    logic                   is_leb;
    logic                   is_signed;
    logic                   done;
    logic                   dropped;

    // A new value starts from a clean state and takes the mode of its first byte.
    always_comb begin
        if (i_ctl.in_value) begin
            cur     = i_ctl;
            cur_acc = i_acc;
        end else begin
            cur.in_value   = 1'b1;
            cur.mode       = t_mode'(i_beat.mode);
            cur.bytes_seen = '0;
            cur.dropped    = 1'b0;
            cur_acc        = '0;
        end
    end

    always_comb begin
        is_leb    = 1'b0;
        is_signed = 1'b0;
        nbytes    = 4'd8;
        unique case (cur.mode)
            MODE_ULEB: begin
                is_leb = 1'b1;
            end
            MODE_SLEB: begin
                is_leb    = 1'b1;
                is_signed = 1'b1;
            end
            MODE_U16: begin
                nbytes = 4'd2;
            end
            MODE_S16: begin
                nbytes    = 4'd2;
                is_signed = 1'b1;
            end
            MODE_U32: begin
                nbytes = 4'd4;
            end
            MODE_S32: begin
                nbytes    = 4'd4;
                is_signed = 1'b1;
            end
            MODE_U64: begin
                nbytes = 4'd8;
            end
            MODE_S64: begin
                nbytes    = 4'd8;
                is_signed = 1'b1;
            end
            default: begin
                nbytes = 4'd8;
            end
        endcase
    end

    assign count      = (cur.bytes_seen < COUNT_MAX) ? cur.bytes_seen + 1'b1 : COUNT_MAX;
    assign bit_pos    = 7'(cur.bytes_seen) * 7'd7;
    assign sext_pos   = bit_pos + 7'd7;
    assign byte_shift = {cur.bytes_seen[2:0], 3'b000};

    always_comb begin
        acc     = cur_acc;
        dropped = cur.dropped;
        if (is_leb) begin
            if (cur.bytes_seen >= LEB_MAX_BYTES) begin
                dropped = 1'b1;
            end
            if (cur.bytes_seen <= LEB_LAST_IDX) begin
                acc = acc | (VALUE_WIDTH'(i_beat.data_byte[6:0]) << bit_pos);
            end
            done = !i_beat.data_byte[7];
            // Sign extension only while the value still fits the full word.
            if (done && is_signed && i_beat.data_byte[6] && (cur.bytes_seen < LEB_LAST_IDX)) begin
                acc = acc | ({VALUE_WIDTH{1'b1}} << sext_pos);
            end
        end else begin
            acc  = acc | (VALUE_WIDTH'(i_beat.data_byte) << byte_shift);
            done = count >= nbytes;
            // The last byte of a fixed value carries its sign bit in bit 7.
            if (done && is_signed && (nbytes != 4'd8) && i_beat.data_byte[7]) begin
                acc = acc | ({VALUE_WIDTH{1'b1}} << {nbytes, 3'b000});
            end
        end
    end

    always_comb begin
        o_ctl            = cur;
        o_ctl.bytes_seen = count;
        o_ctl.dropped    = dropped;
        o_ctl.in_value   = !done;
        o_acc            = acc;
        o_done           = done;
        o_result.decoded_value = DATA_W'(acc);
        o_result.byte_count    = count;
        o_result.overflow      = dropped;
    end

endmodule

### src/dwarf_encoded_value_decoder.sv
// Decoder for DWARF encoded values, fed one byte of the encoded stream per beat.
//
// Input channel (i_in_valid / o_in_ready / i_in_beat): each beat carries one raw
// byte and an encoding mode. The mode is sampled only on the first byte of a
// value and held until that value ends; LEB128 values end at a byte whose top
// bit is clear, fixed values after 2, 4 or 8 little-endian bytes.
// Output channel (o_out_valid / i_out_ready / o_out_beat): one beat per value,
// carrying the value (low VALUE_WIDTH bits kept, sign- or zero-extended), the
// byte count saturating at 15, and an overflow flag for overlong LEB128 values.
//
// Throughput is one byte per cycle unless a byte is held off (see below): each
// byte is one shift-and-OR into the accumulator between the state registers and
// the result register, and the result is output in the cycle after its last byte.
// The result register decouples the two sides: while a result waits, bytes
// that do not end a value are still accepted; only a byte that would end the
// next value is held off until the waiting result has been taken.
// A synchronous reset drops any partly decoded value and empties the output.
module dwarf_encoded_value_decoder
    import dwev_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_W_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    t_ctl                   r_ctl;
    t_ctl                   n_ctl;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic                   r_out_valid;
    t_out_beat              r_out_beat;
    t_out_beat              step_result;
    logic                   step_done;
    logic                   in_accept;
    logic                   out_free;

    // All of the per-byte arithmetic lives in the step logic.
    dwev_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_beat   (i_in_beat),
        .i_ctl    (r_ctl),
        .i_acc    (r_acc),
        .o_ctl    (n_ctl),
        .o_acc    (n_acc),
        .o_done   (step_done),
        .o_result (step_result)
    );

    // The result register is free if it is empty or being emptied this cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = out_free || !step_done;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (in_accept) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && step_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && step_done) begin
            r_out_beat <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // A byte that ends a value always leaves the decoder idle for the next one.
    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && step_done) |=> !r_ctl.in_value)
        else $error("decoder still inside a value after its last byte");

    // Input is only held off by a stalled, full result register.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && !i_out_ready))
        else $error("input stalled without a waiting result");

    // Overflow can only be reported after more bytes than the word holds.
    a_overflow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.overflow) |->
            (o_out_beat.byte_count > COUNT_W'((VALUE_WIDTH + 6) / 7)))
        else $error("overflow flagged on a short value");

    // Every value consumes at least one byte.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.byte_count != '0))
        else $error("result with zero byte count");

endmodule
